[src/assert_macros.svh]
// assertion helpers included by double_ended_queue.sv
// every macro samples on the rising edge of clk; clk and rst must be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// shared widths, operation codes and status codes of the double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEQ_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST_FWD   = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST_BWD   = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [STAT_W-1:0]        stat_t;

endpackage

`default_nettype wire

[src/deq_req_if.sv]
// ----------------------------------------------------------------------------
// deq_req_if
// request channel: one operation and its push word per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if;
  import deq_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  word_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

[src/deq_rsp_if.sv]
// ----------------------------------------------------------------------------
// deq_rsp_if
// response channel: one result word, status and last flag per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_rsp_if;
  import deq_pkg::*;

  logic  valid;
  logic  ready;
  word_t data;
  stat_t status;
  logic  last;

  modport source (output valid, output data, output status, output last, input ready);
  modport sink   (input valid, input data, input status, input last, output ready);
endinterface

`default_nettype wire

[src/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// ring-buffer deque of signed 32-bit words with push, pop and listing
// ----------------------------------------------------------------------------
// The words live in a single DEPTH-entry synchronous memory addressed as a
// ring by a head index and an entry count held in flops. A push writes its
// word and answers in the same cycle, so pushes can be taken every cycle
// while the response side keeps draining. A pop reads the memory, then answers
// from the S_POP state once the response register is free. A listing walks
// the stored words one per read, alternating a read state (S_LIST_RD) and a
// response state (S_LIST_WR) per word. Errors (pop or listing of an empty
// deque, push to a full one) are answered from idle and leave the state as is.
// Op codes 6 and 7 are swallowed without a response. Only one operation is
// in flight at a time, so a write and a later read of the same entry never
// overlap. A response register sits on the output, and a new request is taken
// while the previous response is being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  wire          clk,
  input  wire          rst,
  deq_req_if.sink      req,
  deq_rsp_if.source    rsp
);
  import deq_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   SUM_TOP  = (CNT_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_POP     = 2'd1;
  localparam logic [1:0] S_LIST_RD = 2'd2;
  localparam logic [1:0] S_LIST_WR = 2'd3;

  // ring position of offset off from base, off below DEPTH
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= SUM_TOP) begin
      sum = sum - SUM_TOP;
    end
    return sum[IDX_W-1:0];
  endfunction

  // control state
  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;       // listing position
  logic             list_fwd, list_fwd_next;

  // word memory
  word_t            mem [DEPTH];
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  word_t            rd_data;

  // response register
  logic  out_valid;
  word_t out_data;
  stat_t out_status;
  logic  out_last;
  logic  out_load;
  word_t ld_data;
  stat_t ld_status;
  logic  ld_last;

  logic out_free;
  logic req_accept;
  logic is_full;
  logic is_empty;
  logic idx_last;
  logic push_ok;
  logic list_done;

  assign out_free   = !out_valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && out_free;
  assign req_accept = req.valid && req.ready;
  assign is_full    = (count == CNT_FULL);
  assign is_empty   = (count == '0);
  assign idx_last   = (idx == count - 1'b1);
  assign push_ok    = req_accept && !is_full &&
                      (req.op == OP_PUSH_FRONT || req.op == OP_PUSH_BACK);
  assign list_done  = (state == S_LIST_WR) && out_load && idx_last;

  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    idx_next      = idx;
    list_fwd_next = list_fwd;
    wr_en         = 1'b0;
    wr_addr       = head;
    rd_en         = 1'b0;
    rd_addr       = head;
    out_load      = 1'b0;
    ld_data       = '0;
    ld_status     = STAT_OK;
    ld_last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          unique case (req.op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_load = 1'b1;
              if (is_full) begin
                // word dropped, nothing changes
                ld_status = STAT_FULL;
              end else begin
                wr_en = 1'b1;
                if (req.op == OP_PUSH_FRONT) begin
                  head_next = (head == '0) ? IDX_LAST : head - 1'b1;
                  wr_addr   = head_next;
                end else begin
                  wr_addr = slot(head, count);
                end
                count_next = count + 1'b1;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                out_load  = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                rd_en = 1'b1;
                if (req.op == OP_POP_FRONT) begin
                  rd_addr   = head;
                  head_next = slot(head, CNT_W'(1));
                end else begin
                  rd_addr = slot(head, count - 1'b1);
                end
                count_next = count - 1'b1;
                state_next = S_POP;
              end
            end
            OP_LIST_FWD, OP_LIST_BWD: begin
              if (is_empty) begin
                out_load  = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                idx_next      = '0;
                list_fwd_next = (req.op == OP_LIST_FWD);
                state_next    = S_LIST_RD;
              end
            end
            default: begin
              // unused op codes: no response, no change
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_data    = rd_data;
          state_next = S_IDLE;
        end
      end
      S_LIST_RD: begin
        rd_en      = 1'b1;
        rd_addr    = list_fwd ? slot(head, idx) : slot(head, count - 1'b1 - idx);
        state_next = S_LIST_WR;
      end
      S_LIST_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_data  = rd_data;
          ld_last  = idx_last;
          if (idx_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_LIST_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      idx      <= '0;
      list_fwd <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      idx      <= idx_next;
      list_fwd <= list_fwd_next;
    end
  end

  // word memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data   <= ld_data;
      out_status <= ld_status;
      out_last   <= ld_last;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  // assertions
  `DEQ_ASSERT(a_no_overwrite, out_load |-> out_free, "response overwritten while stalled")
  `DEQ_ASSERT(a_push_grows, push_ok |=> (count == $past(count) + 1'b1), "push lost")
  `DEQ_ASSERT(a_list_ends, list_done |=> (state == S_IDLE), "listing overran")
  `DEQ_ASSERT_ALWAYS(a_count_range, rst || count <= CNT_FULL, "entry count above depth")

endmodule

`default_nettype wire

[tb/double_ended_queue_checker.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// watches both deque channels, predicts every result and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_checker (
  input  wire  clk,
  input  wire  rst,
  deq_req_if   req,
  deq_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   results,
  output int   full_seen,
  output int   empty_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  typedef struct packed {
    word_t data;
    stat_t status;
    logic  last;
  } deq_result_t;

  // predicted contents of the ring and its pointers
  word_t       ring [DEQ_DEPTH];
  int unsigned head;
  int unsigned count;

  deq_result_t owed_results [$];

  function automatic void owe(word_t data, stat_t status, logic last);
    deq_result_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // update the predicted deque for one request and queue what it must return
  function automatic void apply_op(op_t op, word_t value);
    int unsigned pos;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (count >= DEQ_DEPTH) begin
          owe('0, STAT_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head = (head + DEQ_DEPTH - 1) % DEQ_DEPTH;
            ring[head] = value;
          end else begin
            ring[(head + count) % DEQ_DEPTH] = value;
          end
          count++;
          owe('0, STAT_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (count == 0) begin
          owe('0, STAT_EMPTY, 1'b1);
        end else begin
          if (op == OP_POP_FRONT) begin
            pos  = head;
            head = (head + 1) % DEQ_DEPTH;
          end else begin
            pos = (head + count - 1) % DEQ_DEPTH;
          end
          count--;
          owe(ring[pos], STAT_OK, 1'b1);
        end
      end
      OP_LIST_FWD, OP_LIST_BWD: begin
        if (count == 0) begin
          owe('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < count; i++) begin
            pos = (op == OP_LIST_FWD) ? (head + i) % DEQ_DEPTH
                                      : (head + count - 1 - i) % DEQ_DEPTH;
            owe(ring[pos], STAT_OK, i + 1 == count);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    deq_result_t want;
    if (rst) begin
      owed_results.delete();
      head       = 0;
      count      = 0;
      fail_count = 0;
      results    = 0;
      full_seen  = 0;
      empty_seen = 0;
    end else begin
      // a response leaving now always belongs to an earlier request
      if (rsp.valid && rsp.ready) begin
        results++;
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result data=%0d status=%0d last=%0b",
                   $time, rsp.data, rsp.status, rsp.last);
        end else begin
          want = owed_results.pop_front();
          if (want.status == STAT_FULL) full_seen++;
          if (want.status == STAT_EMPTY) empty_seen++;
          if (rsp.data !== want.data || rsp.status !== want.status ||
              rsp.last !== want.last) begin
            fail_count++;
            $display("%0t ns: mismatch expected %s, got %s", $time,
                     $sformatf("data=%0d status=%0d last=%0b",
                               $signed(want.data), want.status, want.last),
                     $sformatf("data=%0d status=%0d last=%0b",
                               rsp.data, rsp.status, rsp.last));
          end
        end
      end
      if (req.valid && req.ready) apply_op(req.op, req.value);
    end
    pending = owed_results.size();
  end

endmodule

`default_nettype wire

[tb/double_ended_queue_tb.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// stimulus and verdict for the ring-buffer deque
// ----------------------------------------------------------------------------
// Drives push, pop and listing requests with random idling on both channels,
// fills the deque past full and drains it past empty, and leaves prediction
// and comparison to the checker, whose failure and pending counts decide the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // op codes the block must swallow without a response
  localparam op_t OP_RSVD_6 = 3'd6;
  localparam op_t OP_RSVD_7 = 3'd7;

  localparam int IDLE_PCT    = 28;
  localparam int RANDOM_OPS  = 290;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 50;   // settle time after the final drain

  logic clk;
  logic rst;

  deq_req_if req_if ();
  deq_rsp_if rsp_if ();

  int fail_count;
  int pending;
  int results;
  int full_seen;
  int empty_seen;

  // pacing controls and counters
  bit idle_mode;       // random idling on both sides when set
  bit hold_request;    // asks the response side for a long hold-off
  int hold_left;
  int ops_sent;

  double_ended_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  double_ended_queue_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .fail_count (fail_count),
    .pending    (pending),
    .results    (results),
    .full_seen  (full_seen),
    .empty_seen (empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("[double_ended_queue] ERROR");
    $finish;
  end

  // response side: random stalls, or a long hold-off counted here when asked
  initial begin
    rsp_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (idle_mode) begin
        rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // one request transaction; returns at the edge that accepts it
  task automatic send(op_t op, word_t value);
    if (idle_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    ops_sent++;
  endtask

  // sender stops until every owed result has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // words lean on the extremes now and then
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    int push_pct;
    int counted;
    int r;

    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.op    <= OP_PUSH_FRONT;
    req_if.value <= '0;
    idle_mode    = 1'b1;
    hold_request = 1'b0;
    ops_sent     = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty deque: every pop and listing must report empty
    send(OP_POP_FRONT, pick_word());
    send(OP_POP_BACK, pick_word());
    send(OP_LIST_FWD, pick_word());
    send(OP_LIST_BWD, pick_word());

    // extremes through both ends, listed both ways, then popped back out
    send(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send(OP_PUSH_BACK, 32'sh8000_0000);
    send(OP_LIST_FWD, '0);
    send(OP_LIST_BWD, -32'sd1);
    send(OP_RSVD_6, word_t'($urandom));
    send(OP_RSVD_7, word_t'($urandom));
    send(OP_POP_BACK, '0);
    send(OP_POP_FRONT, '0);

    // fill past full while the response side holds off, so the input stalls
    hold_request <= 1'b1;
    for (int i = 0; i < DEQ_DEPTH + 2; i++) begin
      send($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    end
    send(OP_LIST_FWD, '0);
    send(OP_LIST_BWD, '0);

    // sender pause until every result is home
    drain();

    // random part: push bias shifts so the deque swings between full and empty
    counted  = 0;
    push_pct = 50;
    while (counted < RANDOM_OPS) begin
      if (counted % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      // a long stretch with no idling on either side
      idle_mode = !(counted >= 100 && counted < 180);
      if (counted == 200) drain();
      if (counted == 240) hold_request <= 1'b1;

      r = $urandom_range(0, 99);
      if (r < 3) begin
        // swallowed op codes do not count toward the item total
        send($urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7, word_t'($urandom));
      end else begin
        if (r < 15) begin
          send($urandom_range(0, 1) ? OP_LIST_FWD : OP_LIST_BWD, pick_word());
        end else if (r < 15 + push_pct * 85 / 100) begin
          send($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
        end else begin
          send($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
        end
        counted++;
      end
    end

    // wind down: everything owed must arrive, then let the block settle
    idle_mode = 1'b1;
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d requests and %0d results checked", ops_sent, results);
    $display("full pushes seen: %0d, empty pops or listings seen: %0d",
             full_seen, empty_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
